[hdl/acsad_pkg.sv]
// Package for the AC swing activity detector.
// Shared widths, defaults, register indexes and inter-module structs.
// No dependencies.
package acsad_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int MIN_W      = 16;
	localparam int CNT_W      = 16;
	localparam int SUM_W      = 16;
	localparam int TDATA_W    = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int RECIP_SH   = 20;

	localparam int WINDOWS_DEF    = 5;
	localparam int SAMPLE_MAX_DEF = 4095;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 12'd100;
	localparam logic [CNT_W-1:0]    WIN_LENGTH_RST = 16'd1000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_THRESHOLD_CH0 = 2'd0,
		CFG_THRESHOLD_CH1 = 2'd1,
		CFG_WINDOW_LENGTH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic             emit;
		logic             ch;
		logic [SUM_W-1:0] sum;
	} trk_res_t;

	typedef struct packed {
		logic s2_vld;
		logic s2_free;
	} avg_stat_t;

endpackage

[hdl/ac_swing_activity_detector_core.sv]
// AC swing activity detector, top level.
// Result path: the sample closing a measurement passes the input register, the average
// stage and the result register before its result beat becomes valid.
// Throughput: one sample per cycle unless a result is blocked at the average stage.
// Reset: asynchronous, clears all channel state and valids, loads register defaults.
// Depends on acsad_pkg, acsad_track, acsad_avg.
module ac_swing_activity_detector_core #(
	parameter int WINDOWS    = acsad_pkg::WINDOWS_DEF,
	parameter int SAMPLE_MAX = acsad_pkg::SAMPLE_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [acsad_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [acsad_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [acsad_pkg::TDATA_W-1:0]    s_tdata,  // [11:0] sample
	input  logic                             s_tuser,  // [0] channel
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [acsad_pkg::TDATA_W-1:0]    m_tdata,  // [11:0] average_swing, [12] running
	output logic                             m_tuser   // [0] out_channel
);

	logic [acsad_pkg::SAMPLE_W-1:0] thr0_q;
	logic [acsad_pkg::SAMPLE_W-1:0] thr1_q;
	logic [acsad_pkg::CNT_W-1:0]    wlen_q;

	logic                           vld_s1;
	logic [acsad_pkg::SAMPLE_W-1:0] sample_s1;
	logic                           ch_s1;
	logic                           adv_s1;

	acsad_pkg::trk_res_t  trk_res;
	acsad_pkg::avg_stat_t avg_stat;

	logic                           out_ch;
	logic [acsad_pkg::SAMPLE_W-1:0] out_avg;
	logic                           out_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr0_q <= acsad_pkg::THRESHOLD_RST;
			thr1_q <= acsad_pkg::THRESHOLD_RST;
			wlen_q <= acsad_pkg::WIN_LENGTH_RST;
		end else if (cfg_we) begin
			case (acsad_pkg::cfg_idx_t'(cfg_addr))
				acsad_pkg::CFG_THRESHOLD_CH0: begin
					thr0_q <= cfg_wdata[acsad_pkg::SAMPLE_W-1:0];
				end
				acsad_pkg::CFG_THRESHOLD_CH1: begin
					thr1_q <= cfg_wdata[acsad_pkg::SAMPLE_W-1:0];
				end
				acsad_pkg::CFG_WINDOW_LENGTH: begin
					wlen_q <= cfg_wdata[acsad_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// a beat without a result never waits on the output side
	assign adv_s1   = vld_s1 && (!trk_res.emit || avg_stat.s2_free);
	assign s_tready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[acsad_pkg::SAMPLE_W-1:0];
			ch_s1     <= s_tuser;
		end
	end

	acsad_track #(
		.WINDOWS    (WINDOWS),
		.SAMPLE_MAX (SAMPLE_MAX)
	) u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv_s1),
		.sample        (sample_s1),
		.ch            (ch_s1),
		.window_length (wlen_q),
		.res           (trk_res)
	);

	acsad_avg #(
		.WINDOWS (WINDOWS)
	) u_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv_s1 && trk_res.emit),
		.res      (trk_res),
		.thr0     (thr0_q),
		.thr1     (thr1_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.out_ch   (out_ch),
		.out_avg  (out_avg),
		.out_run  (out_run),
		.stat     (avg_stat)
	);

	assign m_tdata = {{(acsad_pkg::TDATA_W - acsad_pkg::SAMPLE_W - 1){1'b0}}, out_run, out_avg};
	assign m_tuser = out_ch;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s1 |=> vld_s1 && $stable(sample_s1) && $stable(ch_s1))
		else $error("stalled input beat lost or changed");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_s1 && trk_res.emit && !avg_stat.s2_free)
		else $error("input stalled without a blocked result");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && trk_res.emit |=> avg_stat.s2_vld)
		else $error("finished measurement not captured");

endmodule

[hdl/acsad_track.sv]
// Per-channel window tracker: min/max, sample and window counts, swing sum.
// Combinational read-modify-write of the selected channel's state, registered on adv.
// Depends on acsad_pkg.
module acsad_track #(
	parameter int WINDOWS    = acsad_pkg::WINDOWS_DEF,
	parameter int SAMPLE_MAX = acsad_pkg::SAMPLE_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [acsad_pkg::SAMPLE_W-1:0] sample,
	input  logic                           ch,
	input  logic [acsad_pkg::CNT_W-1:0]    window_length,
	output acsad_pkg::trk_res_t            res
);

	localparam int WC_W = $clog2(WINDOWS + 1);
	localparam logic [acsad_pkg::MIN_W-1:0] MIN_RST = acsad_pkg::MIN_W'(SAMPLE_MAX);
	localparam logic [WC_W-1:0] WC_LAST = WC_W'(WINDOWS);

	logic [acsad_pkg::MIN_W-1:0]    min_q [2];
	logic [acsad_pkg::SAMPLE_W-1:0] max_q [2];
	logic [acsad_pkg::CNT_W-1:0]    cnt_q [2];
	logic [WC_W-1:0]                wc_q  [2];
	logic [acsad_pkg::SUM_W-1:0]    sum_q [2];

	logic [acsad_pkg::CNT_W-1:0]    len;
	logic [acsad_pkg::MIN_W-1:0]    sample_ext;
	logic [acsad_pkg::MIN_W-1:0]    new_min;
	logic [acsad_pkg::SAMPLE_W-1:0] new_max;
	logic [acsad_pkg::CNT_W:0]      cnt_nx;
	logic [acsad_pkg::MIN_W-1:0]    swing;
	logic [acsad_pkg::SUM_W-1:0]    sum_nx;
	logic [WC_W-1:0]                wc_nx;
	logic                           win_done;
	logic                           meas_done;

	always_comb begin
		len        = (window_length == '0) ? acsad_pkg::CNT_W'(1) : window_length;
		sample_ext = acsad_pkg::MIN_W'(sample);
		new_min    = (sample_ext < min_q[ch]) ? sample_ext : min_q[ch];
		new_max    = (sample > max_q[ch]) ? sample : max_q[ch];
		cnt_nx     = {1'b0, cnt_q[ch]} + (acsad_pkg::CNT_W+1)'(1);
		win_done   = cnt_nx >= {1'b0, len};
		// max >= sample >= min once the sample is folded in
		swing      = acsad_pkg::MIN_W'(new_max) - new_min;
		sum_nx     = sum_q[ch] + acsad_pkg::SUM_W'(swing);
		wc_nx      = wc_q[ch] + WC_W'(1);
		meas_done  = win_done && (wc_nx >= WC_LAST);
		res.emit   = meas_done;
		res.ch     = ch;
		res.sum    = sum_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				min_q[i] <= MIN_RST;
				max_q[i] <= '0;
				cnt_q[i] <= '0;
				wc_q[i]  <= '0;
				sum_q[i] <= '0;
			end
		end else if (adv) begin
			if (!win_done) begin
				min_q[ch] <= new_min;
				max_q[ch] <= new_max;
				cnt_q[ch] <= cnt_nx[acsad_pkg::CNT_W-1:0];
			end else begin
				min_q[ch] <= MIN_RST;
				max_q[ch] <= '0;
				cnt_q[ch] <= '0;
				if (meas_done) begin
					wc_q[ch]  <= '0;
					sum_q[ch] <= '0;
				end else begin
					wc_q[ch]  <= wc_nx;
					sum_q[ch] <= sum_nx;
				end
			end
		end
	end

endmodule

[hdl/acsad_avg.sv]
// Averaging stage: sum / WINDOWS by reciprocal multiply, threshold compare,
// result register with its own valid. Depends on acsad_pkg.
module acsad_avg #(
	parameter int WINDOWS = acsad_pkg::WINDOWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  acsad_pkg::trk_res_t            res,
	input  logic [acsad_pkg::SAMPLE_W-1:0] thr0,
	input  logic [acsad_pkg::SAMPLE_W-1:0] thr1,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic                           out_ch,
	output logic [acsad_pkg::SAMPLE_W-1:0] out_avg,
	output logic                           out_run,
	output acsad_pkg::avg_stat_t           stat
);

	localparam int RECIP_W = acsad_pkg::RECIP_SH + 1;
	localparam int PROD_W  = acsad_pkg::SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((2 ** acsad_pkg::RECIP_SH + WINDOWS - 1) / WINDOWS);

	logic                        vld_s2;
	logic                        ch_s2;
	logic [acsad_pkg::SUM_W-1:0] sum_s2;
	logic                        vld_q;
	logic                        out_free;
	logic                        s2_free;
	logic [PROD_W-1:0]           prod;
	logic [acsad_pkg::SAMPLE_W-1:0] avg;
	logic [acsad_pkg::SAMPLE_W-1:0] thr;

	always_comb begin
		out_free = !vld_q || m_tready;
		s2_free  = !vld_s2 || out_free;
		prod     = {{RECIP_W{1'b0}}, sum_s2} * {{acsad_pkg::SUM_W{1'b0}}, RECIP};
		avg      = prod[acsad_pkg::RECIP_SH +: acsad_pkg::SAMPLE_W];
		thr      = ch_s2 ? thr1 : thr0;
		stat.s2_vld  = vld_s2;
		stat.s2_free = s2_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (s2_free)
				vld_s2 <= load;
			if (out_free)
				vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && load) begin
			ch_s2  <= res.ch;
			sum_s2 <= res.sum;
		end
		if (out_free && vld_s2) begin
			out_ch  <= ch_s2;
			out_avg <= avg;
			out_run <= avg > thr;
		end
	end

	assign m_tvalid = vld_q;

endmodule
